>>> src/ibq_pkg.sv
`timescale 1ns / 1ps

package ibq_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int HISTORY_WIDTH_DEF = 24;
    localparam int COEF_WIDTH        = 16;
    localparam int COEF_FRAC         = 14;
    localparam int ACC_WIDTH         = 64;
    localparam int DATA_WIDTH        = 32;
    localparam int ADDR_WIDTH        = 5;
    localparam int REG_IDX_WIDTH     = ADDR_WIDTH - 2;

    localparam logic [REG_IDX_WIDTH-1:0] REG_A1 = REG_IDX_WIDTH'(0);
    localparam logic [REG_IDX_WIDTH-1:0] REG_A2 = REG_IDX_WIDTH'(1);
    localparam logic [REG_IDX_WIDTH-1:0] REG_B0 = REG_IDX_WIDTH'(2);
    localparam logic [REG_IDX_WIDTH-1:0] REG_B1 = REG_IDX_WIDTH'(3);
    localparam logic [REG_IDX_WIDTH-1:0] REG_B2 = REG_IDX_WIDTH'(4);

    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1 << COEF_FRAC);

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX  = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN  = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_HALF = ACC_WIDTH'(1 << (COEF_FRAC - 1));

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
        logic signed [COEF_WIDTH-1:0] b0;
        logic signed [COEF_WIDTH-1:0] b1;
        logic signed [COEF_WIDTH-1:0] b2;
    } ibq_coefs_t;

    typedef enum logic [2:0] {
        TAP_A1,
        TAP_A2,
        TAP_B0,
        TAP_B1,
        TAP_B2
    } ibq_tap_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A1,
        ST_ACC_A1,
        ST_MUL_A2,
        ST_ACC_A2,
        ST_ROUND_W,
        ST_MUL_B0,
        ST_ACC_B0,
        ST_MUL_B1,
        ST_ACC_B1,
        ST_MUL_B2,
        ST_ACC_B2,
        ST_FINISH
    } ibq_state_t;

    typedef struct packed {
        logic     load;
        logic     mul;
        ibq_tap_t tap;
        logic     acc;
        logic     sub;
        logic     round_w;
        logic     finish;
    } ibq_cmd_t;

    typedef struct packed {
        logic out_blocked;
    } ibq_status_t;

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] a,
        input logic signed [ACC_WIDTH-1:0] b
    );
        logic signed [ACC_WIDTH:0] s;
        s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
        begin
            return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_WIDTH-1:0];
    endfunction

endpackage

>>> src/ibq_regs.sv
`timescale 1ns / 1ps

module ibq_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ibq_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [ibq_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [ibq_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                              pready,
    output ibq_pkg::ibq_coefs_t               coefs
);
    import ibq_pkg::*;

    ibq_coefs_t                 coefs_reg;
    ibq_coefs_t                 coefs_next;
    logic [REG_IDX_WIDTH-1:0]   reg_idx;
    logic                       wr_en;
    logic [COEF_WIDTH-1:0]      rd_val;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_WIDTH-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        coefs_next = coefs_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_A1:  coefs_next.a1 = pwdata[COEF_WIDTH-1:0];
                REG_A2:  coefs_next.a2 = pwdata[COEF_WIDTH-1:0];
                REG_B0:  coefs_next.b0 = pwdata[COEF_WIDTH-1:0];
                REG_B1:  coefs_next.b1 = pwdata[COEF_WIDTH-1:0];
                REG_B2:  coefs_next.b2 = pwdata[COEF_WIDTH-1:0];
                default: coefs_next = coefs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.a1 <= '0;
            coefs_reg.a2 <= '0;
            coefs_reg.b0 <= COEF_ONE;
            coefs_reg.b1 <= '0;
            coefs_reg.b2 <= '0;
        end
        else
        begin
            coefs_reg <= coefs_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_A1:  rd_val = coefs_reg.a1;
            REG_A2:  rd_val = coefs_reg.a2;
            REG_B0:  rd_val = coefs_reg.b0;
            REG_B1:  rd_val = coefs_reg.b1;
            REG_B2:  rd_val = coefs_reg.b2;
            default: rd_val = '0;
        endcase
    end

    assign prdata = DATA_WIDTH'(rd_val);
    assign coefs  = coefs_reg;

endmodule

>>> src/ibq_ctrl.sv
`timescale 1ns / 1ps

module ibq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ibq_pkg::ibq_status_t  status,
    output ibq_pkg::ibq_cmd_t     cmd
);
    import ibq_pkg::*;

    ibq_state_t state_reg;
    ibq_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_MUL_A1;
            ST_MUL_A1:  state_next = ST_ACC_A1;
            ST_ACC_A1:  state_next = ST_MUL_A2;
            ST_MUL_A2:  state_next = ST_ACC_A2;
            ST_ACC_A2:  state_next = ST_ROUND_W;
            ST_ROUND_W: state_next = ST_MUL_B0;
            ST_MUL_B0:  state_next = ST_ACC_B0;
            ST_ACC_B0:  state_next = ST_MUL_B1;
            ST_MUL_B1:  state_next = ST_ACC_B1;
            ST_ACC_B1:  state_next = ST_MUL_B2;
            ST_MUL_B2:  state_next = ST_ACC_B2;
            ST_ACC_B2:  state_next = ST_FINISH;
            ST_FINISH:  if (!status.out_blocked) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.tap  = TAP_A1;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_MUL_A1:
            begin
                cmd.mul = 1'b1;
                cmd.tap = TAP_A1;
            end
            ST_MUL_A2:
            begin
                cmd.mul = 1'b1;
                cmd.tap = TAP_A2;
            end
            ST_MUL_B0:
            begin
                cmd.mul = 1'b1;
                cmd.tap = TAP_B0;
            end
            ST_MUL_B1:
            begin
                cmd.mul = 1'b1;
                cmd.tap = TAP_B1;
            end
            ST_MUL_B2:
            begin
                cmd.mul = 1'b1;
                cmd.tap = TAP_B2;
            end
            ST_ACC_A1, ST_ACC_A2:
            begin
                cmd.acc = 1'b1;
                cmd.sub = 1'b1;
            end
            ST_ACC_B0, ST_ACC_B1, ST_ACC_B2:
            begin
                cmd.acc = 1'b1;
            end
            ST_ROUND_W:
            begin
                cmd.round_w = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = !status.out_blocked;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_MUL_A1))
        else $error("accepted request did not start the feedback pass");

    a_finish_unblocked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !status.out_blocked)
        else $error("result written while output register is held");

    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after finish");
`endif

endmodule

>>> src/ibq_datapath.sv
`timescale 1ns / 1ps

module ibq_datapath #(
    parameter int SAMPLE_WIDTH  = ibq_pkg::SAMPLE_WIDTH_DEF,
    parameter int HISTORY_WIDTH = ibq_pkg::HISTORY_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ibq_pkg::ibq_coefs_t             coefs,
    input  ibq_pkg::ibq_cmd_t               cmd,
    output ibq_pkg::ibq_status_t            status,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]  sample_out
);
    import ibq_pkg::*;

    localparam int PROD_WIDTH = COEF_WIDTH + HISTORY_WIDTH;

    logic signed [HISTORY_WIDTH-1:0] d1_reg;
    logic signed [HISTORY_WIDTH-1:0] d2_reg;
    logic signed [HISTORY_WIDTH-1:0] w_reg;
    logic signed [PROD_WIDTH-1:0]    prod_reg;
    logic signed [PROD_WIDTH-1:0]    prod_next;
    logic signed [ACC_WIDTH-1:0]     acc_reg;
    logic signed [ACC_WIDTH-1:0]     acc_next;
    logic signed [SAMPLE_WIDTH-1:0]  sample_out_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;

    logic signed [COEF_WIDTH-1:0]    mul_coef;
    logic signed [HISTORY_WIDTH-1:0] mul_opnd;
    logic signed [ACC_WIDTH-1:0]     prod_ext;
    logic signed [ACC_WIDTH-1:0]     addend;
    logic signed [ACC_WIDTH-1:0]     x_ext;
    logic signed [ACC_WIDTH-1:0]     acc_rnd;
    logic signed [ACC_WIDTH-1:0]     rnd_shift;
    logic signed [ACC_WIDTH-1:0]     w_upper;
    logic signed [ACC_WIDTH-1:0]     y_upper;
    logic signed [HISTORY_WIDTH-1:0] w_sat;
    logic signed [SAMPLE_WIDTH-1:0]  y_sat;

    always_comb
    begin
        case (cmd.tap)
            TAP_A1:
            begin
                mul_coef = coefs.a1;
                mul_opnd = d1_reg;
            end
            TAP_A2:
            begin
                mul_coef = coefs.a2;
                mul_opnd = d2_reg;
            end
            TAP_B0:
            begin
                mul_coef = coefs.b0;
                mul_opnd = w_reg;
            end
            TAP_B1:
            begin
                mul_coef = coefs.b1;
                mul_opnd = d1_reg;
            end
            TAP_B2:
            begin
                mul_coef = coefs.b2;
                mul_opnd = d2_reg;
            end
            default:
            begin
                mul_coef = '0;
                mul_opnd = '0;
            end
        endcase
    end

    assign prod_next = PROD_WIDTH'(mul_coef) * PROD_WIDTH'(mul_opnd);
    assign prod_ext  = ACC_WIDTH'(prod_reg);
    assign addend    = cmd.sub ? -prod_ext : prod_ext;
    assign x_ext     = ACC_WIDTH'(sample_in);

    // round half up, then narrow with saturation
    assign acc_rnd   = sat_add(acc_reg, ACC_HALF);
    assign rnd_shift = acc_rnd >>> COEF_FRAC;
    assign w_upper   = rnd_shift >>> (HISTORY_WIDTH - 1);
    assign y_upper   = rnd_shift >>> (SAMPLE_WIDTH - 1);

    always_comb
    begin
        if (w_upper == '0 || w_upper == '1)
        begin
            w_sat = rnd_shift[HISTORY_WIDTH-1:0];
        end
        else
        begin
            w_sat = {rnd_shift[ACC_WIDTH-1], {(HISTORY_WIDTH-1){~rnd_shift[ACC_WIDTH-1]}}};
        end
        if (y_upper == '0 || y_upper == '1)
        begin
            y_sat = rnd_shift[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            y_sat = {rnd_shift[ACC_WIDTH-1], {(SAMPLE_WIDTH-1){~rnd_shift[ACC_WIDTH-1]}}};
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.load)
        begin
            acc_next = x_ext <<< COEF_FRAC;
        end
        else if (cmd.round_w)
        begin
            acc_next = '0;
        end
        else if (cmd.acc)
        begin
            acc_next = sat_add(acc_reg, addend);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg        <= '0;
            d2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.finish)
            begin
                d2_reg <= d1_reg;
                d1_reg <= w_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.round_w)
        begin
            w_reg <= w_sat;
        end
        if (cmd.finish)
        begin
            sample_out_reg <= y_sat;
        end
    end

    assign status.out_blocked = out_valid_reg && out_stall;
    assign out_valid          = out_valid_reg;
    assign sample_out         = sample_out_reg;

`ifndef NO_ASSERTIONS
    a_history_shift: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (d1_reg == $past(w_reg)) && (d2_reg == $past(d1_reg)))
        else $error("history words did not shift on finish");

    a_history_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.finish |=> $stable(d1_reg) && $stable(d2_reg))
        else $error("history words changed outside finish");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(sample_out_reg))
        else $error("stalled result request changed");
`endif

endmodule

>>> src/iir_biquad_filter_unit.sv
`timescale 1ns / 1ps

// second-order direct-form-II iir filter, q2.14 coefficients
// config: apb-style write/read of a1, a2, b0, b1, b2 at byte offsets 0x0..0x10;
//   pready is always high, writes are expected only while the filter is idle
// input: a request on in_valid/sample_in is taken when in_stall is low
// output: one sample_out request per input, held on out_valid until out_stall is low
// schedule: from input accept to out_valid the controller runs five multiply and
//   five accumulate steps on one shared 16-bit coefficient multiplier, plus two
//   rounding steps
// overlap: no new sample is taken while one is being computed, but a new sample
//   is taken while the previous result waits in the output register
// a stalled receiver holds the result; a second finished result waits in the
//   datapath and the input stays stalled until the output register frees up
// reset: history words cleared, a1 a2 b1 b2 cleared, b0 set to 1.0 (passthrough),
//   no output pending
module iir_biquad_filter_unit #(
    parameter int SAMPLE_WIDTH  = ibq_pkg::SAMPLE_WIDTH_DEF,
    parameter int HISTORY_WIDTH = ibq_pkg::HISTORY_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ibq_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [ibq_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [ibq_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]  sample_out
);
    import ibq_pkg::*;

    ibq_coefs_t  coefs;
    ibq_cmd_t    cmd;
    ibq_status_t status;

    ibq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    ibq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ibq_datapath #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .HISTORY_WIDTH (HISTORY_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .coefs      (coefs),
        .cmd        (cmd),
        .status     (status),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

endmodule

>>> tb/sv/iir_biquad_filter_checker.sv
`timescale 1ns / 1ps

module iir_biquad_filter_checker #(
    parameter int SAMPLE_WIDTH  = ibq_pkg::SAMPLE_WIDTH_DEF,
    parameter int HISTORY_WIDTH = ibq_pkg::HISTORY_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ibq_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [ibq_pkg::DATA_WIDTH-1:0]  pwdata,
    input  logic [ibq_pkg::DATA_WIDTH-1:0]  prdata,
    input  logic                            pready,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample_in,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample_out,
    output int                              errors,
    output int                              pending
);

    import ibq_pkg::*;

    localparam int     COEF_COUNT = REG_B2 + 1;
    localparam longint ACC_HI     = 64'sh7fff_ffff_ffff_ffff;
    localparam longint ACC_LO     = -ACC_HI - 1;

    logic signed [COEF_WIDTH-1:0]   coef_reg [COEF_COUNT];
    longint                         hist_d1;
    longint                         hist_d2;
    logic signed [SAMPLE_WIDTH-1:0] expected_samples [$];
    logic signed [SAMPLE_WIDTH-1:0] oldest_sample;
    logic [REG_IDX_WIDTH-1:0]       reg_idx;

    assign reg_idx = paddr[ADDR_WIDTH-1:2];

    function automatic longint acc_add(longint a, longint b);
        longint s;
        s = a + b;
        if (a >= 0 && b >= 0 && s < 0)
            return ACC_HI;
        if (a < 0 && b < 0 && s >= 0)
            return ACC_LO;
        return s;
    endfunction

    // round half up, then drop the fraction bits
    function automatic longint round_q(longint acc);
        longint v;
        v = acc_add(acc, longint'(1) <<< (COEF_FRAC - 1));
        return v >>> COEF_FRAC;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] filter_step(
        logic signed [SAMPLE_WIDTH-1:0] x
    );
        longint acc;
        longint w;
        longint y;
        acc = longint'(x) <<< COEF_FRAC;
        acc = acc_add(acc, -(longint'(coef_reg[REG_A1]) * hist_d1));
        acc = acc_add(acc, -(longint'(coef_reg[REG_A2]) * hist_d2));
        w   = clamp(round_q(acc), HISTORY_WIDTH);
        acc = longint'(coef_reg[REG_B0]) * w;
        acc = acc_add(acc, longint'(coef_reg[REG_B1]) * hist_d1);
        acc = acc_add(acc, longint'(coef_reg[REG_B2]) * hist_d2);
        y   = clamp(round_q(acc), SAMPLE_WIDTH);
        hist_d2 = hist_d1;
        hist_d1 = w;
        return y[SAMPLE_WIDTH-1:0];
    endfunction

    task automatic report_mismatch(string what, longint want, longint got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[REG_A1] = '0;
            coef_reg[REG_A2] = '0;
            coef_reg[REG_B0] = COEF_ONE;
            coef_reg[REG_B1] = '0;
            coef_reg[REG_B2] = '0;
            hist_d1 = 0;
            hist_d2 = 0;
            expected_samples.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pready && reg_idx < COEF_COUNT)
            begin
                if (pwrite)
                begin
                    coef_reg[reg_idx] = pwdata[COEF_WIDTH-1:0];
                end
                else if (prdata[COEF_WIDTH-1:0] !== coef_reg[reg_idx])
                begin
                    report_mismatch("register read", longint'(coef_reg[reg_idx]),
                                    longint'($signed(prdata[COEF_WIDTH-1:0])));
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected sample_out %0d", $time, sample_out);
                end
                else
                begin
                    oldest_sample = expected_samples.pop_front();
                    if (sample_out !== oldest_sample)
                        report_mismatch("sample_out", longint'(oldest_sample),
                                        longint'(sample_out));
                end
            end
            if (in_valid && !in_stall)
                expected_samples.push_back(filter_step(sample_in));
            pending = expected_samples.size();
        end
    end

endmodule

>>> tb/sv/iir_biquad_filter_unit_tb.sv
`timescale 1ns / 1ps

module iir_biquad_filter_unit_tb;

    import ibq_pkg::*;

    localparam int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF;
    localparam int COEF_COUNT      = REG_B2 + 1;
    localparam int QUIET_LIMIT     = 3000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 160;

    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [COEF_WIDTH-1:0]   C_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic signed [COEF_WIDTH-1:0]   C_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

    typedef enum int {
        COEFS_RANDOM,
        COEFS_STABLE,
        COEFS_ALL_MAX,
        COEFS_ALL_MIN,
        COEFS_CORNERS
    } coef_mode_t;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           psel       = 1'b0;
    logic                           penable    = 1'b0;
    logic                           pwrite     = 1'b0;
    logic [ADDR_WIDTH-1:0]          paddr      = '0;
    logic [DATA_WIDTH-1:0]          pwdata     = '0;
    logic [DATA_WIDTH-1:0]          prdata;
    logic                           pready;
    logic                           in_valid   = 1'b0;
    logic                           in_stall;
    logic signed [SAMPLE_WIDTH-1:0] sample_in  = '0;
    logic                           out_valid;
    logic                           out_stall  = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    int                             errors;
    int                             pending;
    int                             quiet_cycles = 0;
    bit                             gaps_on      = 1'b1;
    logic signed [COEF_WIDTH-1:0]   coef_set [COEF_COUNT];

    iir_biquad_filter_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

    iir_biquad_filter_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .errors     (errors),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        out_stall <= gaps_on && ($urandom_range(0, 99) < 12);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (psel && penable && pready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("iir_biquad_filter_unit test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_sample(logic signed [SAMPLE_WIDTH-1:0] value);
        while (gaps_on && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic bus_access(bit write, int idx, logic [DATA_WIDTH-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {REG_IDX_WIDTH'(idx), 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_coefs();
        wait_drained();
        for (int i = REG_A1; i <= REG_B2; i++)
            bus_access(1'b1, i, {16'($urandom), coef_set[REG_IDX_WIDTH'(i)]});
        // writes past the last register must not land anywhere
        if ($urandom_range(0, 1))
            bus_access(1'b1, $urandom_range(COEF_COUNT, (1 << REG_IDX_WIDTH) - 1), $urandom);
        for (int i = REG_A1; i <= REG_B2; i++)
            bus_access(1'b0, i, '0);
    endtask

    function automatic logic signed [COEF_WIDTH-1:0] corner_coef();
        case ($urandom_range(0, 2))
            0:       return C_MAX;
            1:       return C_MIN;
            default: return '0;
        endcase
    endfunction

    task automatic pick_coefs(coef_mode_t mode);
        for (int i = REG_A1; i <= REG_B2; i++)
        begin
            case (mode)
                COEFS_ALL_MAX: coef_set[REG_IDX_WIDTH'(i)] = C_MAX;
                COEFS_ALL_MIN: coef_set[REG_IDX_WIDTH'(i)] = C_MIN;
                COEFS_CORNERS: coef_set[REG_IDX_WIDTH'(i)] = corner_coef();
                COEFS_STABLE:
                    coef_set[REG_IDX_WIDTH'(i)] = COEF_WIDTH'($urandom_range(0, 16384) - 8192);
                default:       coef_set[REG_IDX_WIDTH'(i)] = COEF_WIDTH'($urandom);
            endcase
        end
        if (mode == COEFS_STABLE)
        begin
            coef_set[REG_A1] = COEF_WIDTH'($urandom_range(0, 40000) - 20000);
            coef_set[REG_A2] = COEF_WIDTH'($urandom_range(0, 14000));
        end
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            case ($urandom_range(0, 3))
                0:       return S_MAX;
                1:       return S_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        if (roll < 30)
            return SAMPLE_WIDTH'($urandom_range(0, 511) - 256);
        return SAMPLE_WIDTH'($urandom);
    endfunction

    initial
    begin
        coef_mode_t mode;
        int         pause_at;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset coefficients pass samples straight through
        push_sample(S_MAX);
        push_sample(S_MIN);
        push_sample('0);
        push_sample(SAMPLE_WIDTH'(1));
        push_sample('1);
        push_sample(16'sh5555);
        push_sample(16'shaaaa);

        // b0 of one half puts ties exactly on the rounding point
        coef_set[REG_A1] = '0;
        coef_set[REG_A2] = '0;
        coef_set[REG_B0] = COEF_ONE >>> 1;
        coef_set[REG_B1] = '0;
        coef_set[REG_B2] = '0;
        program_coefs();
        push_sample(SAMPLE_WIDTH'(1));
        push_sample(SAMPLE_WIDTH'(-1));
        push_sample(SAMPLE_WIDTH'(3));
        push_sample(SAMPLE_WIDTH'(-3));

        // runaway feedback drives the history words and the output into saturation
        coef_set[REG_A1] = C_MIN;
        coef_set[REG_A2] = C_MIN;
        coef_set[REG_B0] = C_MAX;
        coef_set[REG_B1] = C_MAX;
        coef_set[REG_B2] = C_MAX;
        program_coefs();
        repeat (5) push_sample(S_MAX);
        repeat (5) push_sample(S_MIN);
        repeat (2) push_sample('0);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                1:       mode = COEFS_ALL_MAX;
                2:       mode = COEFS_ALL_MIN;
                3:       mode = COEFS_CORNERS;
                default: mode = (p % 2) ? COEFS_RANDOM : COEFS_STABLE;
            endcase
            pick_coefs(mode);
            program_coefs();
            gaps_on  = (p != 5);
            pause_at = $urandom_range(10, ITEMS_PER_PHASE - 10);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (i == pause_at)
                    wait_drained();
                push_sample(pick_sample());
            end
        end
        gaps_on = 1'b1;

        wait_drained();
        repeat (30) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("iir_biquad_filter_unit test passed");
        else
            $display("iir_biquad_filter_unit test failed");
        $finish;
    end

endmodule
